@@ rtl/mdt_pkg.sv @@
package mdt_pkg;

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int TPM_W    = 16;
    localparam int US_W     = 16;
    localparam int TIMER_W  = 16;
    localparam int TAG_W    = 8;
    localparam int TICKS_W  = 23;
    // delay held as us * ticks_per_ms, i.e. ticks scaled by 1000
    localparam int SCALED_W = US_W + TPM_W;
    localparam int EL_SCALED_W = TIMER_W + 10;

    localparam logic [TPM_W-1:0] TPM_RESET  = 16'd922;
    localparam logic             MODE_RESET = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_TICKS_PER_MS = 1'b0;
    localparam logic REG_AUTO_RELOAD  = 1'b1;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [EL_SCALED_W-1:0] TICK_SCALE = 26'd1000;
    localparam logic [SCALED_W:0]      ROUND_ADD  = 33'd999;

    // floor(y / 125) = (y * RECIP_MUL) >> RECIP_SHIFT for y below 2**30
    localparam int RECIP_Y_W   = SCALED_W + 1 - 3;
    localparam int RECIP_M_W   = 31;
    localparam int RECIP_SHIFT = 37;
    localparam logic [RECIP_M_W-1:0] RECIP_MUL = 31'd1099511628;

    typedef struct packed {
        logic [TPM_W-1:0] ticks_per_ms;
        logic             auto_reload_mode;
    } cfg_t;

endpackage

@@ rtl/mdt_regs.sv @@
module mdt_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mdt_pkg::ADDR_W-1:0]     paddr,
    input  logic [mdt_pkg::DATA_W-1:0]     pwdata,
    output logic [mdt_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output mdt_pkg::cfg_t                  cfg
);

    logic [mdt_pkg::TPM_W-1:0] tpm_reg;
    logic                      mode_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg  <= mdt_pkg::TPM_RESET;
            mode_reg <= mdt_pkg::MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                mdt_pkg::REG_TICKS_PER_MS: tpm_reg  <= pwdata[mdt_pkg::TPM_W-1:0];
                mdt_pkg::REG_AUTO_RELOAD:  mode_reg <= pwdata[0];
                default:                   tpm_reg  <= tpm_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mdt_pkg::REG_TICKS_PER_MS:
                prdata = {{(mdt_pkg::DATA_W-mdt_pkg::TPM_W){1'b0}}, tpm_reg};
            mdt_pkg::REG_AUTO_RELOAD:
                prdata = {{(mdt_pkg::DATA_W-1){1'b0}}, mode_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.ticks_per_ms     = tpm_reg;
    assign cfg.auto_reload_mode = mode_reg;

endmodule

@@ rtl/microsecond_delay_tracker_core.sv @@
// an accepted item beat passes the input register, stage 1 and stage 2 on its way to its result beat
// throughput: one item per cycle while result_stall does not hold the pipeline; the delay state is updated
// as an item leaves the input register, the ticks_left conversion (divide by 1000) is a two-stage pipeline behind it
// reset: idle, no delay armed, ticks_per_ms = 922, auto-reload mode on
module microsecond_delay_tracker_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mdt_pkg::ADDR_W-1:0]      paddr,
    input  logic [mdt_pkg::DATA_W-1:0]      pwdata,
    output logic [mdt_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            kind,
    input  logic [mdt_pkg::US_W-1:0]        delay_us,
    input  logic [mdt_pkg::TIMER_W-1:0]     timer_value,
    input  logic [mdt_pkg::TAG_W-1:0]       reload_tag,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            finished,
    output logic [mdt_pkg::TICKS_W-1:0]     ticks_left
);

    localparam int SW  = mdt_pkg::SCALED_W;
    localparam int TW  = mdt_pkg::TIMER_W;
    localparam int PW  = mdt_pkg::RECIP_Y_W + mdt_pkg::RECIP_M_W;

    mdt_pkg::cfg_t cfg;

    mdt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage valids and handshake
    logic v0_reg, v1_reg, v2_reg;
    logic ready0, ready1, ready2;
    logic fire0;

    assign ready2     = !v2_reg || !result_stall;
    assign ready1     = !v1_reg || ready2;
    assign ready0     = !v0_reg || ready1;
    assign item_stall = !ready0;
    assign fire0      = v0_reg && ready1;

    // input register
    logic                           kind_reg;
    logic [mdt_pkg::US_W-1:0]       us_reg;
    logic [TW-1:0]                  cur_reg;
    logic [mdt_pkg::TAG_W-1:0]      tag_reg;

    always_ff @(posedge clk)
    begin
        if (item_valid && ready0)
        begin
            kind_reg <= kind;
            us_reg   <= delay_us;
            cur_reg  <= timer_value;
            tag_reg  <= reload_tag;
        end
    end

    // delay state
    logic                           waiting_reg, waiting_next;
    logic [SW-1:0]                  rem_reg, rem_next;
    logic [TW-1:0]                  last_timer_reg, last_timer_next;
    logic [mdt_pkg::TAG_W-1:0]      last_tag_reg, last_tag_next;

    logic [TW-1:0]                  elapsed;
    logic [mdt_pkg::EL_SCALED_W-1:0] el_scaled;
    logic [SW-1:0]                  el_wide;
    logic [SW-1:0]                  start_prod;
    logic                           fin_next;
    logic [SW-1:0]                  res_rem_next;

    always_comb
    begin
        if (cfg.auto_reload_mode)
        begin
            if (cur_reg >= last_timer_reg)
                elapsed = cur_reg - last_timer_reg;
            else
                elapsed = cfg.ticks_per_ms - (last_timer_reg - cur_reg);
        end
        else if (tag_reg == last_tag_reg)
        begin
            elapsed = cur_reg - last_timer_reg;
        end
        else
        begin
            // only the ticks since the reload value 65536 - ticks_per_ms
            elapsed = cur_reg + cfg.ticks_per_ms;
        end
    end

    assign el_scaled  = mdt_pkg::EL_SCALED_W'(elapsed) * mdt_pkg::TICK_SCALE;
    assign el_wide    = SW'(el_scaled);
    assign start_prod = SW'(us_reg) * SW'(cfg.ticks_per_ms);

    always_comb
    begin
        waiting_next    = waiting_reg;
        rem_next        = rem_reg;
        last_timer_next = last_timer_reg;
        last_tag_next   = last_tag_reg;
        fin_next        = 1'b0;
        res_rem_next    = '0;
        if (fire0)
        begin
            if (kind_reg == mdt_pkg::KIND_START)
            begin
                if (us_reg == '0)
                begin
                    waiting_next = 1'b0;
                    rem_next     = '0;
                    fin_next     = 1'b1;
                end
                else
                begin
                    waiting_next    = 1'b1;
                    rem_next        = start_prod;
                    last_timer_next = cur_reg;
                    last_tag_next   = tag_reg;
                    res_rem_next    = start_prod;
                end
            end
            else if (waiting_reg)
            begin
                // elapsed >= ceil(rem / 1000) exactly when 1000 * elapsed >= rem
                if (el_wide >= rem_reg)
                begin
                    waiting_next = 1'b0;
                    rem_next     = '0;
                    fin_next     = 1'b1;
                end
                else
                begin
                    rem_next        = rem_reg - el_wide;
                    last_timer_next = cur_reg;
                    last_tag_next   = tag_reg;
                    res_rem_next    = rem_reg - el_wide;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg    <= 1'b0;
            rem_reg        <= '0;
            last_timer_reg <= '0;
            last_tag_reg   <= '0;
        end
        else
        begin
            waiting_reg    <= waiting_next;
            rem_reg        <= rem_next;
            last_timer_reg <= last_timer_next;
            last_tag_reg   <= last_tag_next;
        end
    end

    // stage 1: scaled remainder of this item
    logic           fin1_reg;
    logic [SW-1:0]  rem1_reg;

    always_ff @(posedge clk)
    begin
        if (fire0)
        begin
            fin1_reg <= fin_next;
            rem1_reg <= res_rem_next;
        end
    end

    // stage 2: ceil(rem / 1000) = floor(floor((rem + 999) / 8) / 125)
    logic [SW:0]                        rounded;
    logic [mdt_pkg::RECIP_Y_W-1:0]      eighth;
    logic [PW-1:0]                      recip_prod;

    assign rounded    = {1'b0, rem1_reg} + mdt_pkg::ROUND_ADD;
    assign eighth     = rounded[SW:3];
    assign recip_prod = PW'(eighth) * PW'(mdt_pkg::RECIP_MUL);

    logic                           fin2_reg;
    logic [mdt_pkg::TICKS_W-1:0]    ticks2_reg;

    always_ff @(posedge clk)
    begin
        if (v1_reg && ready2)
        begin
            fin2_reg   <= fin1_reg;
            ticks2_reg <= recip_prod[mdt_pkg::RECIP_SHIFT +: mdt_pkg::TICKS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
                v0_reg <= item_valid;
            if (ready1)
                v1_reg <= v0_reg;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    assign result_valid = v2_reg;
    assign finished     = fin2_reg;
    assign ticks_left   = ticks2_reg;

endmodule
